[hdl/rfc_epoch_pkg.sv]
// Package for the RFC 3339 timestamp to epoch block: item structs, state enums,
// arithmetic constants and the month offset table. No dependencies.
package rfc_epoch_pkg;

   localparam int EPOCH_W = 38;
   localparam int ACC_W   = 43;
   localparam int OPA_W   = 25;
   localparam int OPB_W   = 17;

   localparam logic [4:0]       FIXED_LAST   = 5'd18;
   localparam logic [4:0]       ZONE_LAST    = 5'd4;
   localparam logic [OPB_W-1:0] RECIP_100    = 17'd5243;
   localparam int               RECIP_SHIFT  = 19;
   localparam logic [OPB_W-1:0] DAYS_YEAR    = 17'd365;
   localparam logic [OPB_W-1:0] SECS_DAY     = 17'd86400;
   localparam logic [OPB_W-1:0] SECS_HOUR    = 17'd3600;
   localparam logic [OPB_W-1:0] SECS_MINUTE  = 17'd60;
   localparam logic [OPB_W-1:0] UNIT_ONE     = 17'd1;
   localparam logic [13:0]      ERA_SHIFT    = 14'd400;
   // Era shift, civil shift and the minus one of the day number together.
   localparam logic [OPA_W-1:0] DATE_BIAS    = 25'd865566;

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_T     = 8'h54;
   localparam logic [7:0] CH_UZ    = 8'h5A;
   localparam logic [7:0] CH_LZ    = 8'h7A;

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic               valid_res;
      logic [EPOCH_W-1:0] epoch_seconds;
   } rsp_type;

   typedef enum logic [2:0] {
      PH_FIXED,
      PH_AFTER,
      PH_FRAC,
      PH_ZONE,
      PH_DONE
   } phase_type;

   typedef enum logic [3:0] {
      ST_PARSE,
      ST_QUO,
      ST_YEAR,
      ST_QUARTER,
      ST_CENTURY,
      ST_QUAD,
      ST_DATE,
      ST_SCALE,
      ST_HOUR,
      ST_MINUTE,
      ST_SECOND,
      ST_ZHOUR,
      ST_ZMIN,
      ST_FINISH
   } seq_state_type;

   // Days from March 1 to the first of the given month.
   function automatic logic [8:0] month_offset(input logic [6:0] month);
      logic [8:0] days;
      case (month)
         7'd3:    days = 9'd0;
         7'd4:    days = 9'd31;
         7'd5:    days = 9'd61;
         7'd6:    days = 9'd92;
         7'd7:    days = 9'd122;
         7'd8:    days = 9'd153;
         7'd9:    days = 9'd184;
         7'd10:   days = 9'd214;
         7'd11:   days = 9'd245;
         7'd12:   days = 9'd275;
         7'd1:    days = 9'd306;
         7'd2:    days = 9'd337;
         default: days = 9'd0;
      endcase
      return days;
   endfunction

   function automatic logic [6:0] add_digit(input logic [6:0] value, input logic [3:0] digit);
      logic [10:0] sum;
      sum = {4'b0, value} * 11'd10 + {7'b0, digit};
      return sum[6:0];
   endfunction

endpackage

[hdl/rfc3339_timestamp_to_epoch_top.sv]
// Top level of the RFC 3339 timestamp to epoch block: character parser and a
// sequencer around one shared multiply-accumulate unit. Uses rfc_epoch_pkg.
//
// Characters are taken one per cycle in the parse state, also while a result
// waits, except an end marker. Valid text runs the multiply-accumulate states from
// quotient to zone minutes, rejected text goes straight to the finish state, which
// loads the result; no item is taken until it is loaded. Reset is synchronous,
// active high, and returns the parser to the start of a text with no result pending.
module rfc3339_timestamp_to_epoch_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  rfc_epoch_pkg::req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rfc_epoch_pkg::rsp_type rsp_payload
);
   import rfc_epoch_pkg::*;

   seq_state_type state_ff, state_in;
   phase_type     phase_ff, phase_in;
   logic [4:0]    pos_ff, pos_in;
   logic          rej_ff, rej_in;
   logic [13:0]   year_ff, year_in;
   logic [6:0]    month_ff, month_in, day_ff, day_in, hour_ff, hour_in;
   logic [6:0]    minute_ff, minute_in, second_ff, second_in;
   logic          zneg_ff, zneg_in;
   logic [6:0]    zhour_ff, zhour_in, zmin_ff, zmin_in;
   logic          ok_ff, ok_in;
   logic [6:0]    quo_ff, quo_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;

   logic                    req_fire, is_dig, reject_now, text_ok, slot_free;
   logic [3:0]              dig;
   logic [7:0]              ch;
   logic [13:0]             year_adj;
   logic [OPA_W-1:0]        op_a;
   logic [OPB_W-1:0]        op_b;
   logic                    op_load, op_sub;
   logic signed [ACC_W-1:0] product;
   logic [17:0]             year_sum;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_PARSE) || (rsp_valid_ff && req_payload.end_of_text);
   assign req_fire  = req_valid && !req_stall;
   assign ch        = req_payload.char_code;
   assign is_dig    = (ch >= CH_ZERO) && (ch <= CH_NINE);
   assign dig       = 4'(ch - CH_ZERO);
   assign year_sum  = {4'b0, year_ff} * 18'd10 + {14'b0, dig};

   assign text_ok = !rej_ff && (phase_ff == PH_AFTER || phase_ff == PH_FRAC ||
                    phase_ff == PH_DONE) && month_ff >= 7'd1 && month_ff <= 7'd12 &&
                    day_ff >= 7'd1 && day_ff <= 7'd31 && hour_ff <= 7'd23 &&
                    minute_ff <= 7'd59 && second_ff <= 7'd60 && zhour_ff <= 7'd23 &&
                    zmin_ff <= 7'd59;

   assign year_adj = year_ff + ERA_SHIFT - {13'b0, (month_ff <= 7'd2)};

   assign product = ACC_W'($signed(op_a) * $signed({1'b0, op_b}));

   always_comb begin
      phase_in     = phase_ff;
      pos_in       = pos_ff;
      rej_in       = rej_ff;
      year_in      = year_ff;
      month_in     = month_ff;
      day_in       = day_ff;
      hour_in      = hour_ff;
      minute_in    = minute_ff;
      second_in    = second_ff;
      zneg_in      = zneg_ff;
      zhour_in     = zhour_ff;
      zmin_in      = zmin_ff;
      reject_now   = 1'b0;
      if (req_fire && !req_payload.end_of_text && !rej_ff) begin
         case (phase_ff)
            PH_FIXED: begin
               case (pos_ff)
                  5'd4, 5'd7: reject_now = (ch != CH_DASH);
                  5'd10:      reject_now = (ch != CH_T);
                  5'd13, 5'd16: reject_now = (ch != CH_COLON);
                  default: begin
                     if (!is_dig) begin
                        reject_now = 1'b1;
                     end else if (pos_ff < 5'd4) begin
                        year_in = year_sum[13:0];
                     end else if (pos_ff < 5'd7) begin
                        month_in = add_digit(month_ff, dig);
                     end else if (pos_ff < 5'd10) begin
                        day_in = add_digit(day_ff, dig);
                     end else if (pos_ff < 5'd13) begin
                        hour_in = add_digit(hour_ff, dig);
                     end else if (pos_ff < 5'd16) begin
                        minute_in = add_digit(minute_ff, dig);
                     end else begin
                        second_in = add_digit(second_ff, dig);
                     end
                  end
               endcase
               if (!reject_now) begin
                  if (pos_ff == FIXED_LAST) begin
                     phase_in = PH_AFTER;
                     pos_in   = 5'd0;
                  end else begin
                     pos_in = pos_ff + 5'd1;
                  end
               end
            end
            PH_AFTER, PH_FRAC: begin
               if (phase_ff == PH_AFTER && ch == CH_DOT) begin
                  phase_in = PH_FRAC;
               end else if (phase_ff == PH_FRAC && is_dig) begin
                  phase_in = PH_FRAC;
               end else if (ch == CH_UZ || ch == CH_LZ) begin
                  phase_in = PH_DONE;
               end else if (ch == CH_PLUS || ch == CH_DASH) begin
                  zneg_in  = (ch == CH_DASH);
                  phase_in = PH_ZONE;
                  pos_in   = 5'd0;
               end else begin
                  reject_now = 1'b1;
               end
            end
            PH_ZONE: begin
               if (pos_ff == 5'd2) begin
                  reject_now = (ch != CH_COLON);
               end else if (!is_dig) begin
                  reject_now = 1'b1;
               end else if (pos_ff < 5'd2) begin
                  zhour_in = add_digit(zhour_ff, dig);
               end else begin
                  zmin_in = add_digit(zmin_ff, dig);
               end
               if (!reject_now) begin
                  if (pos_ff == ZONE_LAST) begin
                     phase_in = PH_DONE;
                     pos_in   = 5'd0;
                  end else begin
                     pos_in = pos_ff + 5'd1;
                  end
               end
            end
            default: reject_now = 1'b1;
         endcase
         if (reject_now) begin
            rej_in = 1'b1;
         end
      end
      if (state_ff == ST_FINISH && slot_free) begin
         phase_in  = PH_FIXED;
         pos_in    = 5'd0;
         rej_in    = 1'b0;
         year_in   = 14'd0;
         month_in  = 7'd0;
         day_in    = 7'd0;
         hour_in   = 7'd0;
         minute_in = 7'd0;
         second_in = 7'd0;
         zneg_in   = 1'b0;
         zhour_in  = 7'd0;
         zmin_in   = 7'd0;
      end
   end

   always_comb begin
      state_in     = state_ff;
      ok_in        = ok_ff;
      quo_in       = quo_ff;
      acc_in       = acc_ff;
      op_a         = {OPA_W{1'b0}};
      op_b         = UNIT_ONE;
      op_load      = 1'b0;
      op_sub       = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_PARSE: begin
            if (req_fire && req_payload.end_of_text) begin
               ok_in    = text_ok;
               acc_in   = {ACC_W{1'b0}};
               state_in = text_ok ? ST_QUO : ST_FINISH;
            end
         end
         ST_QUO: begin
            op_a     = OPA_W'(year_adj);
            op_b     = RECIP_100;
            quo_in   = product[RECIP_SHIFT+6:RECIP_SHIFT];
            state_in = ST_YEAR;
         end
         ST_YEAR: begin
            op_a     = OPA_W'(year_adj);
            op_b     = DAYS_YEAR;
            op_load  = 1'b1;
            state_in = ST_QUARTER;
         end
         ST_QUARTER: begin
            op_a     = OPA_W'(year_adj[13:2]);
            state_in = ST_CENTURY;
         end
         ST_CENTURY: begin
            op_a     = OPA_W'(quo_ff);
            op_sub   = 1'b1;
            state_in = ST_QUAD;
         end
         ST_QUAD: begin
            op_a     = OPA_W'(quo_ff[6:2]);
            state_in = ST_DATE;
         end
         ST_DATE: begin
            op_a     = OPA_W'(month_offset(month_ff)) + OPA_W'(day_ff) - DATE_BIAS;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            op_a     = acc_ff[OPA_W-1:0];
            op_b     = SECS_DAY;
            op_load  = 1'b1;
            state_in = ST_HOUR;
         end
         ST_HOUR: begin
            op_a     = OPA_W'(hour_ff);
            op_b     = SECS_HOUR;
            state_in = ST_MINUTE;
         end
         ST_MINUTE: begin
            op_a     = OPA_W'(minute_ff);
            op_b     = SECS_MINUTE;
            state_in = ST_SECOND;
         end
         ST_SECOND: begin
            op_a     = OPA_W'(second_ff);
            state_in = ST_ZHOUR;
         end
         ST_ZHOUR: begin
            op_a     = OPA_W'(zhour_ff);
            op_b     = SECS_HOUR;
            op_sub   = !zneg_ff;
            state_in = ST_ZMIN;
         end
         ST_ZMIN: begin
            op_a     = OPA_W'(zmin_ff);
            op_b     = SECS_MINUTE;
            op_sub   = !zneg_ff;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (slot_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.valid_res     = ok_ff && !acc_ff[ACC_W-1];
               rsp_data_in.epoch_seconds = (ok_ff && !acc_ff[ACC_W-1]) ?
                                           acc_ff[EPOCH_W-1:0] : {EPOCH_W{1'b0}};
               state_in                  = ST_PARSE;
            end
         end
         default: state_in = ST_PARSE;
      endcase
      if (state_ff != ST_PARSE && state_ff != ST_QUO && state_ff != ST_FINISH) begin
         if (op_load) begin
            acc_in = product;
         end else if (op_sub) begin
            acc_in = acc_ff - product;
         end else begin
            acc_in = acc_ff + product;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_PARSE;
         phase_ff     <= PH_FIXED;
         pos_ff       <= 5'd0;
         rej_ff       <= 1'b0;
         year_ff      <= 14'd0;
         month_ff     <= 7'd0;
         day_ff       <= 7'd0;
         hour_ff      <= 7'd0;
         minute_ff    <= 7'd0;
         second_ff    <= 7'd0;
         zneg_ff      <= 1'b0;
         zhour_ff     <= 7'd0;
         zmin_ff      <= 7'd0;
         ok_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         rej_ff       <= rej_in;
         year_ff      <= year_in;
         month_ff     <= month_in;
         day_ff       <= day_in;
         hour_ff      <= hour_in;
         minute_ff    <= minute_in;
         second_ff    <= second_in;
         zneg_ff      <= zneg_in;
         zhour_ff     <= zhour_in;
         zmin_ff      <= zmin_in;
         ok_ff        <= ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff      <= quo_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule
